// ===== hdl/ies_pkg.sv =====
`default_nettype none
package ies_pkg;
    localparam int NumBuckets = 16;
    localparam int EventsPerBucket = 8;
    localparam int GateIdBits = 10;
    localparam int TimeBits = 32;
    localparam int TagBits = 16;
    localparam int BktBits = $clog2(NumBuckets);
    localparam int SlotBits = (EventsPerBucket > 1) ? $clog2(EventsPerBucket) : 1;
    localparam int CntBits = $clog2(EventsPerBucket + 1);
    localparam int AddrBits = $clog2(NumBuckets * EventsPerBucket);
    localparam int EntryBits = 1 + GateIdBits + TagBits;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_DISCARDED = 3'd1;
    localparam logic [2:0] ST_POPPED    = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_POP = 1'b1;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic min_step;
        logic mem_rd;
        logic commit_add;
        logic pop_step;
        logic pop_free;
    } ies_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic scan_done;
        logic hit;
        logic min_done;
        logic any_valid;
        logic pop_last;
    } ies_sts_t;
endpackage
`default_nettype wire

// ===== hdl/ies_datapath.sv =====
`default_nettype none
module ies_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ies_pkg::ies_cmd_t              cmd,
    output ies_pkg::ies_sts_t                   sts,
    input  wire logic                           opcode,
    input  wire logic [31:0]                    event_time,
    input  wire logic                           has_gate,
    input  wire logic [9:0]                     gate_id,
    input  wire logic [15:0]                    gate_delay,
    input  wire logic [15:0]                    event_tag,
    output logic [2:0]                          add_status,
    output logic [31:0]                         pop_time,
    output logic                                pop_has_gate,
    output logic [9:0]                          pop_gate_id,
    output logic [15:0]                         pop_tag
);
    localparam int NB = ies_pkg::NumBuckets;
    localparam int EPB = ies_pkg::EventsPerBucket;

    logic [NB-1:0]                     valid_reg;
    logic [ies_pkg::CntBits-1:0]       count_reg [NB];
    logic [ies_pkg::TimeBits-1:0]      btime_reg [NB];
    logic [ies_pkg::EntryBits-1:0]     mem [NB*EPB];
    logic [ies_pkg::EntryBits-1:0]     rd_reg;

    logic                              op_reg;
    logic [ies_pkg::TimeBits-1:0]      t_reg;
    logic                              hg_reg;
    logic [ies_pkg::GateIdBits-1:0]    gid_reg;
    logic [15:0]                       d_reg;
    logic [15:0]                       tag_reg;

    logic [ies_pkg::BktBits:0]         b_reg;
    logic [ies_pkg::CntBits-1:0]       j_reg;
    logic                              hit_reg;
    logic                              rd_ok_reg;
    logic [ies_pkg::BktBits-1:0]       best_reg;
    logic                              found_reg;

    logic [ies_pkg::BktBits-1:0]       bi;
    logic                              win;
    logic [ies_pkg::TimeBits:0]        lo;
    logic [ies_pkg::AddrBits-1:0]      rd_addr;
    logic                              in_bucket;
    logic                              eq_any;
    logic [ies_pkg::BktBits-1:0]       eq_idx;
    logic                              free_any;
    logic [ies_pkg::BktBits-1:0]       free_idx;
    logic [ies_pkg::BktBits-1:0]       wb;
    logic [ies_pkg::SlotBits-1:0]      ws;

    assign bi = b_reg[ies_pkg::BktBits-1:0];
    assign lo = {1'b0, t_reg} - {{(ies_pkg::TimeBits-15){1'b0}}, d_reg};
    assign win = lo[ies_pkg::TimeBits] || (btime_reg[bi] > lo[ies_pkg::TimeBits-1:0]);
    assign in_bucket = valid_reg[bi] && win && (j_reg < count_reg[bi]);
    assign rd_addr = ies_pkg::AddrBits'(bi * EPB) + ies_pkg::AddrBits'(j_reg);

    always_comb
    begin
        eq_any = 1'b0;
        eq_idx = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NB - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && btime_reg[i] == t_reg)
            begin
                eq_any = 1'b1;
                eq_idx = ies_pkg::BktBits'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = ies_pkg::BktBits'(i);
            end
        end
    end

    always_comb
    begin
        if (hit_reg)
            add_status = ies_pkg::ST_DISCARDED;
        else if (eq_any)
            add_status = (count_reg[eq_idx] >= ies_pkg::CntBits'(EPB))
                         ? ies_pkg::ST_FULL : ies_pkg::ST_ADDED;
        else
            add_status = free_any ? ies_pkg::ST_ADDED : ies_pkg::ST_FULL;
    end

    assign wb = eq_any ? eq_idx : free_idx;
    assign ws = eq_any ? count_reg[eq_idx][ies_pkg::SlotBits-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.commit_add && add_status == ies_pkg::ST_ADDED)
            mem[ies_pkg::AddrBits'(wb * EPB) + ies_pkg::AddrBits'(ws)]
                <= {hg_reg, hg_reg ? gid_reg : {ies_pkg::GateIdBits{1'b0}}, tag_reg};
        if (cmd.mem_rd)
            rd_reg <= mem[cmd.pop_step
                ? ies_pkg::AddrBits'(best_reg * EPB) + ies_pkg::AddrBits'(j_reg)
                : rd_addr];
        if (cmd.load)
        begin
            op_reg  <= opcode;
            t_reg   <= event_time;
            hg_reg  <= has_gate;
            gid_reg <= gate_id;
            d_reg   <= gate_delay;
            tag_reg <= event_tag;
        end
        if (cmd.commit_add && add_status == ies_pkg::ST_ADDED && !eq_any)
            btime_reg[free_idx] <= t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < NB; i++)
                count_reg[i] <= '0;
            b_reg <= '0;
            j_reg <= '0;
            hit_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            best_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                b_reg <= '0;
                j_reg <= '0;
                hit_reg <= 1'b0;
                rd_ok_reg <= 1'b0;
                found_reg <= 1'b0;
                best_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                if (rd_ok_reg && rd_reg[ies_pkg::EntryBits-1]
                    && rd_reg[ies_pkg::TagBits +: ies_pkg::GateIdBits] == gid_reg)
                    hit_reg <= 1'b1;
                if (!sts.scan_done && !b_reg[ies_pkg::BktBits])
                begin
                    rd_ok_reg <= in_bucket;
                    if (in_bucket && j_reg < ies_pkg::CntBits'(EPB - 1))
                        j_reg <= j_reg + 1'b1;
                    else
                    begin
                        j_reg <= '0;
                        b_reg <= b_reg + 1'b1;
                    end
                end
                else
                    rd_ok_reg <= 1'b0;
            end
            if (cmd.min_step && !b_reg[ies_pkg::BktBits])
            begin
                if (valid_reg[bi] && (!found_reg || btime_reg[bi] < btime_reg[best_reg]))
                begin
                    best_reg <= bi;
                    found_reg <= 1'b1;
                end
                b_reg <= b_reg + 1'b1;
            end
            if (cmd.commit_add && add_status == ies_pkg::ST_ADDED)
            begin
                valid_reg[wb] <= 1'b1;
                count_reg[wb] <= eq_any ? count_reg[eq_idx] + 1'b1 : ies_pkg::CntBits'(1);
            end
            if (cmd.pop_step)
                j_reg <= j_reg + 1'b1;
            if (cmd.pop_free)
            begin
                valid_reg[best_reg] <= 1'b0;
                count_reg[best_reg] <= '0;
            end
        end
    end

    assign sts.is_pop    = op_reg;
    assign sts.scan_done = !hg_reg || hit_reg || (b_reg[ies_pkg::BktBits] && !rd_ok_reg);
    assign sts.hit       = hit_reg;
    assign sts.min_done  = b_reg[ies_pkg::BktBits];
    assign sts.any_valid = found_reg;
    assign sts.pop_last  = (j_reg + 1'b1) >= count_reg[best_reg];

    assign pop_time     = btime_reg[best_reg];
    assign pop_has_gate = rd_reg[ies_pkg::EntryBits-1];
    assign pop_gate_id  = rd_reg[ies_pkg::TagBits +: ies_pkg::GateIdBits];
    assign pop_tag      = rd_reg[ies_pkg::TagBits-1:0];
endmodule
`default_nettype wire

// ===== hdl/ies_ctrl.sv =====
`default_nettype none
module ies_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output ies_pkg::ies_cmd_t           cmd,
    input  wire ies_pkg::ies_sts_t      sts,
    input  wire logic [2:0]             add_status,
    output logic                        res_load,
    output logic [2:0]                  res_status,
    output logic                        res_pop,
    output logic                        res_last
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_MIN   = 7'b0001000,
        S_RD    = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   wait_pop_reg;

    assign out_valid = out_valid_reg;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        res_load = 1'b0;
        res_status = add_status;
        res_pop = 1'b0;
        res_last = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.scan_start = 1'b1;
                state_next = sts.is_pop ? S_MIN : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.mem_rd = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.commit_add = !sts.hit;
                    res_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MIN:
            begin
                cmd.min_step = 1'b1;
                if (sts.min_done)
                begin
                    if (sts.any_valid)
                        state_next = S_RD;
                    else
                    begin
                        res_load = 1'b1;
                        res_status = ies_pkg::ST_EMPTY;
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.pop_step = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    res_load = 1'b1;
                    res_status = ies_pkg::ST_POPPED;
                    res_pop = 1'b1;
                    res_last = wait_pop_reg;
                    if (wait_pop_reg)
                    begin
                        cmd.pop_free = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            wait_pop_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_RD)
                wait_pop_reg <= sts.pop_last;
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/inertial_event_scheduler.sv =====
// Inertial-delay event queue held as time buckets.
// Input channel (in_valid/in_ready): opcode 0 adds an event, 1 pops the
// earliest bucket. Output channel (out_valid/out_ready): one beat per add
// or empty pop, one beat per event of a popped bucket, last set on the final
// beat of an input.
// A gated add walks the valid buckets in its window one stored event per
// cycle, stopping at the first gate match; an ungated add skips the walk.
// A pop walks the buckets for the minimum time: an empty pop then answers
// at once, otherwise the events of that bucket are read and emitted one at
// a time, each waiting for the result register to be free. The sequencer
// handles one item at a time; the next item is taken once the result
// register is empty.
// Reset clears all bucket valid bits and counts; the queue is empty after
// reset. Event memory contents need no reset.
// A stall on out_ready holds the result register and the sequencer; no beat
// is dropped.
`default_nettype none
module inertial_event_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [31:0] event_time,
    input  wire logic        has_gate,
    input  wire logic [9:0]  gate_id,
    input  wire logic [15:0] gate_delay,
    input  wire logic [15:0] event_tag,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      out_time,
    output logic             out_has_gate,
    output logic [9:0]       out_gate_id,
    output logic [15:0]      out_tag,
    output logic             last
);
    ies_pkg::ies_cmd_t cmd;
    ies_pkg::ies_sts_t sts;
    logic [2:0]  add_status, res_status;
    logic        res_load, res_pop, res_last;
    logic [31:0] pop_time;
    logic        pop_has_gate;
    logic [9:0]  pop_gate_id;
    logic [15:0] pop_tag;

    ies_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
        .cmd, .sts, .add_status, .res_load, .res_status, .res_pop, .res_last
    );

    ies_datapath u_dp (
        .clk, .rst_n, .cmd, .sts, .opcode, .event_time, .has_gate, .gate_id,
        .gate_delay, .event_tag, .add_status, .pop_time, .pop_has_gate,
        .pop_gate_id, .pop_tag
    );

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status       <= res_status;
            out_time     <= res_pop ? pop_time : '0;
            out_has_gate <= res_pop ? pop_has_gate : 1'b0;
            out_gate_id  <= res_pop ? pop_gate_id : '0;
            out_tag      <= res_pop ? pop_tag : '0;
            last         <= res_last;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ies_checker.sv =====
`default_nettype none
module ies_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] status,
    input wire logic       last
);
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ies_pkg::ST_FULL))
        else $error("status out of range");
    a_nonpop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ies_pkg::ST_POPPED) |-> last)
        else $error("single result without last");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(last)))
        else $error("stalled beat changed");
endmodule

bind inertial_event_scheduler ies_checker u_ies_checker (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .status, .last
);
`default_nettype wire
